// ----- design/handle_to_slot_allocator_core_macros.svh -----
// Assertion macros shared by the allocator checker.
// Depends on nothing; included by files that assert.
`ifndef HANDLE_TO_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define HANDLE_TO_SLOT_ALLOCATOR_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HSA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HSA_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- design/hsa_pkg.sv -----
// Package for the handle-to-slot allocator: sizes, payload structs and codes.
// Used by the allocator core and the checker; depends on nothing.
`default_nettype none
package hsa_pkg;
  localparam int unsigned MaxSlots     = 128;
  localparam int unsigned DefaultCount = 7;
  localparam int unsigned SlotW        = $clog2(MaxSlots);
  localparam int unsigned CountW       = $clog2(MaxSlots + 1);
  localparam int unsigned DefW         = $clog2(DefaultCount + 1);
  localparam logic [1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_RESET   = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_ALLOC     = 3'd1;
  localparam logic [2:0] ST_RELEASED  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_RESET     = 3'd5;
  localparam logic [1:0] RB_NONE    = 2'd0;
  localparam logic [1:0] RB_HANDLE  = 2'd1;
  localparam logic [1:0] RB_DEFAULT = 2'd2;
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] handle;
  } req_t;
  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [2:0]       status;
    logic [1:0]       rebind;
  } rsp_t;
endpackage
`default_nettype wire

// ----- design/hsa_free_stack.sv -----
// Free-slot stack: a synchronous memory with a registered pop read.
// Depends on hsa_pkg only through the slot width passed by the parent.
`default_nettype none
module hsa_free_stack #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [AW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [AW-1:0] rd_data
);
  logic [AW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- design/hsa_key_table.sv -----
// Key table: a synchronous memory holding one 32-bit handle per slot.
// One write port and one registered read port; depends on nothing else.
`default_nettype none
module hsa_key_table #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_key,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [31:0]   rd_key
);
  logic [31:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_key;
    end
    rd_key <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- design/handle_to_slot_allocator_core.sv -----
// Handle-to-slot allocator. Requests are worked on one at a time. A lookup or
// release scans the key memory from slot 0 upward, one entry per cycle, up to
// the never-used counter (no slot at or above it can be valid), and stops at
// the lowest valid slot whose key matches. A reset command steps through the
// DefaultCount (7) default slots, writing each captured default key back, and
// the unused command code goes straight to the commit state. A new request
// transfer is taken in the cycle after the response is loaded, once the
// receiver takes that response, so the scan length sets the rate. A lookup
// that misses takes a slot from the free stack first, then from the
// never-used counter, else reports full. A release frees the matching slot,
// pushes it and asks for a default rebind. The reset command restores the
// captured default keys in slots 0 to DefaultCount-1. The response register
// holds a result until its transfer.
// Depends on hsa_pkg, hsa_key_table and hsa_free_stack.
`default_nettype none
module handle_to_slot_allocator_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hsa_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hsa_pkg::rsp_t      out_data
);
  localparam int unsigned Slots = hsa_pkg::MaxSlots;
  localparam int unsigned NDef  = hsa_pkg::DefaultCount;
  localparam int unsigned AW    = hsa_pkg::SlotW;
  localparam int unsigned CW    = hsa_pkg::CountW;
  localparam int unsigned DW    = hsa_pkg::DefW;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_RESTORE} state_t;

  state_t           state;
  // Request held while it is worked on.
  hsa_pkg::req_t    req;
  logic [Slots-1:0] valid;
  logic [CW-1:0]    free_count;
  logic [CW-1:0]    next_unused;
  logic [DW-1:0]    defaults_seen;
  logic [31:0]      default_key [NDef];
  // Scan position, and the entry whose key arrives from the memory this cycle.
  logic [CW-1:0]    scan_idx;
  logic             chk_pending;
  logic [AW-1:0]    chk_idx;
  logic             hit;
  logic [AW-1:0]    hit_slot;
  logic [DW-1:0]    restore_idx;

  logic [31:0]      rd_key;
  logic [AW-1:0]    key_rd_addr;
  logic             key_wr_en;
  logic [AW-1:0]    key_wr_addr;
  logic [31:0]      key_wr_data;
  logic [AW-1:0]    pop_data;
  logic [AW-1:0]    pop_addr;
  logic             match;
  logic             scan_more;
  logic             restore_wr;

  // Decision made in the commit cycle.
  logic             tbl_wr, tbl_clr, push_en, can_alloc;
  logic [AW-1:0]    alloc_slot;
  logic [Slots-1:0] set_mask;
  hsa_pkg::rsp_t    rsp_next;

  assign in_ready    = (state == S_IDLE) && (!out_valid || out_ready);
  assign pop_addr    = AW'(free_count - CW'(1));
  assign key_rd_addr = AW'(scan_idx);
  assign match       = chk_pending && valid[chk_idx] && (rd_key == req.handle);
  assign scan_more   = scan_idx < next_unused;
  assign restore_wr  = (state == S_RESTORE) && (restore_idx < defaults_seen);

  // The reset command writes the default keys back one slot per cycle; any
  // other write is the allocation made in the commit cycle.
  always_comb begin
    if (state == S_RESTORE) begin
      key_wr_en   = restore_wr;
      key_wr_addr = AW'(restore_idx);
      key_wr_data = default_key[restore_idx];
    end else begin
      key_wr_en   = (state == S_COMMIT) && tbl_wr;
      key_wr_addr = alloc_slot;
      key_wr_data = req.handle;
    end
  end

  // Only defaults that were actually captured become valid after a reset.
  always_comb begin
    set_mask = '0;
    for (int k = 0; k < NDef; k++) begin
      set_mask[k] = DW'(k) < defaults_seen;
    end
  end

  always_comb begin
    tbl_wr = 1'b0;
    tbl_clr = 1'b0;
    push_en = 1'b0;
    can_alloc = (free_count != '0) || (next_unused < CW'(Slots));
    alloc_slot = (free_count != '0) ? pop_data : AW'(next_unused);
    rsp_next = '{slot: '0, status: hsa_pkg::ST_NOT_FOUND,
                 rebind: hsa_pkg::RB_NONE};
    unique case (req.cmd)
      hsa_pkg::CMD_LOOKUP: begin
        if (hit) begin
          rsp_next = '{slot: hit_slot, status: hsa_pkg::ST_HIT,
                       rebind: hsa_pkg::RB_NONE};
        end else if (can_alloc) begin
          tbl_wr = 1'b1;
          rsp_next = '{slot: alloc_slot, status: hsa_pkg::ST_ALLOC,
                       rebind: hsa_pkg::RB_HANDLE};
        end else begin
          rsp_next.status = hsa_pkg::ST_FULL;
        end
      end
      hsa_pkg::CMD_RELEASE: begin
        if (hit) begin
          tbl_clr = 1'b1;
          push_en = free_count < CW'(Slots);
          rsp_next = '{slot: hit_slot, status: hsa_pkg::ST_RELEASED,
                       rebind: hsa_pkg::RB_DEFAULT};
        end
      end
      hsa_pkg::CMD_RESET: begin
        rsp_next = '{slot: AW'(NDef), status: hsa_pkg::ST_RESET,
                     rebind: hsa_pkg::RB_DEFAULT};
      end
      default: begin
        rsp_next.status = hsa_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  hsa_key_table #(.DEPTH(Slots), .AW(AW)) u_table (
    .clk(clk), .wr_en(key_wr_en), .wr_addr(key_wr_addr), .wr_key(key_wr_data),
    .rd_addr(key_rd_addr), .rd_key(rd_key)
  );

  hsa_free_stack #(.DEPTH(Slots), .AW(AW)) u_stack (
    .clk(clk), .wr_en((state == S_COMMIT) && push_en), .wr_addr(AW'(free_count)),
    .wr_data(hit_slot), .rd_addr(pop_addr), .rd_data(pop_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      valid <= '0;
      free_count <= '0;
      next_unused <= '0;
      defaults_seen <= '0;
      chk_pending <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            scan_idx <= '0;
            chk_pending <= 1'b0;
            restore_idx <= '0;
            hit <= 1'b0;
            unique case (in_data.cmd) inside
              hsa_pkg::CMD_LOOKUP, hsa_pkg::CMD_RELEASE: begin
                state <= S_SCAN;
              end
              hsa_pkg::CMD_RESET: begin
                // Every entry is dropped and the captured defaults come back.
                valid <= set_mask;
                state <= S_RESTORE;
              end
              default: begin
                state <= S_COMMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Each cycle checks the key read last cycle and issues the next read.
          if (match) begin
            hit <= 1'b1;
            hit_slot <= chk_idx;
            chk_pending <= 1'b0;
            state <= S_COMMIT;
          end else if (scan_more) begin
            chk_pending <= 1'b1;
            chk_idx <= AW'(scan_idx);
            scan_idx <= scan_idx + CW'(1);
          end else begin
            chk_pending <= 1'b0;
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
          out_data <= rsp_next;
          if (tbl_wr) begin
            valid[alloc_slot] <= 1'b1;
            if (free_count != '0) begin
              free_count <= free_count - CW'(1);
            end else begin
              next_unused <= next_unused + CW'(1);
            end
            if (defaults_seen < DW'(NDef)) begin
              default_key[defaults_seen] <= req.handle;
              defaults_seen <= defaults_seen + DW'(1);
            end
          end
          if (tbl_clr) begin
            valid[hit_slot] <= 1'b0;
          end
          if (push_en) begin
            free_count <= free_count + CW'(1);
          end
        end
        S_RESTORE: begin
          if (restore_idx == DW'(NDef - 1)) begin
            state <= S_IDLE;
            out_valid <= 1'b1;
            out_data <= rsp_next;
            free_count <= '0;
            next_unused <= CW'(NDef);
          end else begin
            restore_idx <= restore_idx + DW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/hsa_checker.sv -----
// Port-level checker for the allocator, bound to the allocator core.
// Depends on hsa_pkg and the assertion macro header.
`default_nettype none
`include "handle_to_slot_allocator_core_macros.svh"
module hsa_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire hsa_pkg::rsp_t out_data
);
  logic stall;
  logic taken;
  logic shows_alloc;
  assign stall = out_valid && !out_ready;
  assign taken = in_valid && in_ready;
  assign shows_alloc = out_valid && (out_data.status == hsa_pkg::ST_ALLOC);
  `HSA_ASSERT_NXT(a_stall_hold, clk, rst, stall, out_valid && $stable(out_data))
  `HSA_ASSERT_NXT(a_one_busy, clk, rst, taken, !in_ready)
  `HSA_ASSERT_IMP(a_status_range, clk, rst, out_valid, out_data.status <= hsa_pkg::ST_RESET)
  `HSA_ASSERT_IMP(a_alloc_bind, clk, rst, shows_alloc, out_data.rebind == hsa_pkg::RB_HANDLE)
endmodule
bind handle_to_slot_allocator_core hsa_checker u_chk (.*);
`default_nettype wire
